// ===== hdl/psg_pkg.sv =====
// psg_pkg: shared types, constants and the volume table for the tone/noise sound generator
// used by psg_front, psg_fifo, psg_back and the top level; depends on nothing
package psg_pkg;

  localparam int NUM_TONES  = 3;
  localparam int NUM_CH     = NUM_TONES + 1;
  localparam int FIFO_DEPTH = 4;

  localparam int PERIOD_W = 10;
  localparam int ATT_W    = 4;
  localparam int VOL_W    = 12;
  localparam int PROD_W   = 20;
  localparam int QUOT_W   = 13;
  localparam int LEVEL_W  = 15;
  localparam int SHIFT_W  = 16;
  localparam int RECIP_W  = 21;
  localparam int RPROD_W  = PROD_W + RECIP_W;

  // input operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // configuration register indexes
  localparam int          CFG_IDX_W   = 2;
  localparam logic [1:0]  CFG_VARIANT = 2'd0;
  localparam logic [1:0]  CFG_PREAMP  = 2'd1;
  localparam logic [1:0]  CFG_PANNING = 2'd2;

  // bus register indexes
  localparam logic [2:0] REG_TONE0_PERIOD = 3'd0;
  localparam logic [2:0] REG_TONE0_ATT    = 3'd1;
  localparam logic [2:0] REG_TONE1_PERIOD = 3'd2;
  localparam logic [2:0] REG_TONE1_ATT    = 3'd3;
  localparam logic [2:0] REG_TONE2_PERIOD = 3'd4;
  localparam logic [2:0] REG_TONE2_ATT    = 3'd5;
  localparam logic [2:0] REG_NOISE_CTRL   = 3'd6;
  localparam logic [2:0] REG_NOISE_ATT    = 3'd7;
  localparam logic [2:0] LATCH_RESET      = REG_TONE1_ATT;

  // noise base period and lfsr parameters per chip variant
  localparam logic [PERIOD_W-1:0] NOISE_BASE   = 10'h010;
  localparam logic [SHIFT_W-1:0]  TOP_DISCRETE = 16'h4000;
  localparam logic [SHIFT_W-1:0]  TOP_INTEGR   = 16'h8000;
  localparam logic [SHIFT_W-1:0]  TAPS_DISCRETE = 16'h0006;
  localparam logic [SHIFT_W-1:0]  TAPS_INTEGR   = 16'h0009;

  // divide by 100: floor(p * RECIP / 2^RECIP_SHIFT), exact for p < 2^20
  localparam logic [RECIP_W-1:0] RECIP       = 21'd1342178;
  localparam int                 RECIP_SHIFT = 27;
  localparam logic [PROD_W:0]    PCT_SCALE   = 21'd100;

  typedef struct packed {
    logic [NUM_CH-1:0]            high;
    logic [NUM_CH-1:0][ATT_W-1:0] att;
  } snap_t;

  function automatic logic [VOL_W-1:0] vol_lut(input logic [ATT_W-1:0] a);
    logic [VOL_W-1:0] v;
    case (a)
      4'd0:    v = 12'd2800;
      4'd1:    v = 12'd2224;
      4'd2:    v = 12'd1766;
      4'd3:    v = 12'd1403;
      4'd4:    v = 12'd1114;
      4'd5:    v = 12'd885;
      4'd6:    v = 12'd703;
      4'd7:    v = 12'd558;
      4'd8:    v = 12'd443;
      4'd9:    v = 12'd352;
      4'd10:   v = 12'd280;
      4'd11:   v = 12'd222;
      4'd12:   v = 12'd176;
      4'd13:   v = 12'd140;
      4'd14:   v = 12'd111;
      default: v = 12'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/psg_tone_noise_generator.sv =====
// Throughput: one item per cycle; the output pipeline and the FIFO_DEPTH entry queue
// absorb output stalls, and in_stall rises only when that queue is full.
// Reset: synchronous, active low; restores register defaults, silent channels and a
// seeded noise register. Configuration writes are always ready and apply next cycle.
module psg_tone_noise_generator #(
  parameter int FIFO_DEPTH = psg_pkg::FIFO_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_operation,
  input  logic [7:0]                      in_data_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [psg_pkg::LEVEL_W-1:0]     out_left_level,
  output logic [psg_pkg::LEVEL_W-1:0]     out_right_level,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [psg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [7:0]                      cfg_data
);

  logic           variant_r;
  logic [7:0]     preamp_r;
  logic [7:0]     panning_r;
  logic           in_fire;
  logic           q_full, q_empty, q_pop;
  psg_pkg::snap_t snap, q_data;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign in_fire   = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      variant_r <= 1'b1;
      preamp_r  <= 8'd100;
      panning_r <= 8'hff;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        psg_pkg::CFG_VARIANT: variant_r <= cfg_data[0];
        psg_pkg::CFG_PREAMP:  preamp_r  <= cfg_data;
        psg_pkg::CFG_PANNING: panning_r <= cfg_data;
        default: ;
      endcase
    end
  end

  psg_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .chip_variant (variant_r),
    .in_fire      (in_fire),
    .in_operation (in_operation),
    .in_data_byte (in_data_byte),
    .snap         (snap)
  );

  psg_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_fire),
    .wr_data (snap),
    .pop     (q_pop),
    .rd_data (q_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  psg_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .preamp          (preamp_r),
    .panning         (panning_r),
    .q_valid         (!q_empty),
    .q_data          (q_data),
    .pop             (q_pop),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_left_level  (out_left_level),
    .out_right_level (out_right_level)
  );

endmodule

// ===== hdl/psg_front.sv =====
// psg_front: decodes bus writes and ticks, keeps periods, counters, polarities and the lfsr
// hands the channel levels and attenuations after each item to the queue; uses psg_pkg
module psg_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  chip_variant,
  input  logic                  in_fire,
  input  logic                  in_operation,
  input  logic [7:0]            in_data_byte,
  output psg_pkg::snap_t        snap
);

  logic [2:0]                                        latched_idx_r, latched_idx_nxt;
  logic [psg_pkg::NUM_TONES-1:0][psg_pkg::PERIOD_W-1:0] period_r, period_nxt;
  logic [psg_pkg::NUM_CH-1:0][psg_pkg::ATT_W-1:0]    att_r, att_nxt;
  logic [2:0]                                        noise_ctrl_r, noise_ctrl_nxt;
  logic [psg_pkg::NUM_CH-1:0][psg_pkg::PERIOD_W-1:0] cnt_r, cnt_nxt;
  logic [psg_pkg::NUM_CH-1:0]                        pol_r, pol_nxt;
  logic [psg_pkg::SHIFT_W-1:0]                       shift_r, shift_nxt;

  logic [2:0]                    idx;
  logic [1:0]                    ch;
  logic [psg_pkg::PERIOD_W-1:0]  noise_reload;
  logic [psg_pkg::SHIFT_W-1:0]   taps;
  logic [psg_pkg::SHIFT_W-1:0]   top;
  logic                          fill;

  // period minus one, with a zero period mapped by chip variant
  function automatic logic [psg_pkg::PERIOD_W-1:0] tone_reload(
    input logic [psg_pkg::PERIOD_W-1:0] p,
    input logic                         v
  );
    logic [psg_pkg::PERIOD_W-1:0] r;
    if (p == '0) begin
      r = v ? '0 : '1;
    end else begin
      r = p - 1'b1;
    end
    return r;
  endfunction

  assign idx  = in_data_byte[7] ? in_data_byte[6:4] : latched_idx_r;
  assign ch   = idx[2:1];
  assign taps = chip_variant ? psg_pkg::TAPS_INTEGR : psg_pkg::TAPS_DISCRETE;
  assign top  = chip_variant ? psg_pkg::TOP_INTEGR : psg_pkg::TOP_DISCRETE;
  assign fill = noise_ctrl_r[2] ? ^(shift_r & taps) : shift_r[0];

  always_comb begin
    case (noise_ctrl_r[1:0])
      2'd3:    noise_reload = tone_reload(period_r[psg_pkg::NUM_TONES-1], chip_variant);
      default: noise_reload = (psg_pkg::NOISE_BASE << noise_ctrl_r[1:0]) - 1'b1;
    endcase
  end

  always_comb begin
    latched_idx_nxt = latched_idx_r;
    period_nxt      = period_r;
    att_nxt         = att_r;
    noise_ctrl_nxt  = noise_ctrl_r;
    cnt_nxt         = cnt_r;
    pol_nxt         = pol_r;
    shift_nxt       = shift_r;
    if (in_operation == psg_pkg::OP_TICK) begin
      for (int i = 0; i < psg_pkg::NUM_CH; i++) begin
        if (cnt_r[i] == '0) begin
          pol_nxt[i] = ~pol_r[i];
          if (i < psg_pkg::NUM_TONES) begin
            cnt_nxt[i] = tone_reload(period_r[i], chip_variant);
          end else begin
            cnt_nxt[i] = noise_reload;
          end
        end else begin
          cnt_nxt[i] = cnt_r[i] - 1'b1;
        end
      end
      // noise shifts on the rising edge of its polarity
      if (cnt_r[psg_pkg::NUM_TONES] == '0 && !pol_r[psg_pkg::NUM_TONES]) begin
        shift_nxt = {1'b0, shift_r[psg_pkg::SHIFT_W-1:1]} | (fill ? top : '0);
      end
    end else begin
      if (in_data_byte[7]) begin
        latched_idx_nxt = in_data_byte[6:4];
      end
      case (idx)
        psg_pkg::REG_TONE0_PERIOD, psg_pkg::REG_TONE1_PERIOD,
        psg_pkg::REG_TONE2_PERIOD: begin
          if (in_data_byte[7]) begin
            period_nxt[ch][3:0] = in_data_byte[3:0];
          end else begin
            period_nxt[ch][9:4] = in_data_byte[5:0];
          end
        end
        psg_pkg::REG_NOISE_CTRL: begin
          noise_ctrl_nxt = in_data_byte[2:0];
          // noise clocked by tone 2 picks up its count
          if (in_data_byte[1:0] == 2'b11) begin
            cnt_nxt[psg_pkg::NUM_TONES] = cnt_r[psg_pkg::NUM_TONES-1];
          end
          shift_nxt = top;
        end
        default: begin
          att_nxt[ch] = in_data_byte[3:0];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latched_idx_r <= psg_pkg::LATCH_RESET;
      period_r      <= '0;
      att_r         <= '1;
      noise_ctrl_r  <= '0;
      cnt_r         <= '0;
      pol_r         <= '0;
      shift_r       <= psg_pkg::TOP_INTEGR;
    end else if (in_fire) begin
      latched_idx_r <= latched_idx_nxt;
      period_r      <= period_nxt;
      att_r         <= att_nxt;
      noise_ctrl_r  <= noise_ctrl_nxt;
      cnt_r         <= cnt_nxt;
      pol_r         <= pol_nxt;
      shift_r       <= shift_nxt;
    end
  end

  assign snap.high = {shift_nxt[0], pol_nxt[psg_pkg::NUM_TONES-1:0]};
  assign snap.att  = att_nxt;

`ifndef SYNTHESIS
  a_noise_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_operation == psg_pkg::OP_WRITE && idx == psg_pkg::REG_NOISE_CTRL &&
     in_data_byte[1:0] == 2'b11)
    |=> cnt_r[psg_pkg::NUM_TONES] == $past(cnt_r[psg_pkg::NUM_TONES-1]))
    else $error("noise count not synced to tone 2");
`endif

endmodule

// ===== hdl/psg_fifo.sv =====
// psg_fifo: small queue of channel snapshots between the front and back parts
// uses psg_pkg::snap_t
module psg_fifo #(
  parameter int DEPTH = psg_pkg::FIFO_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  psg_pkg::snap_t wr_data,
  input  logic           pop,
  output psg_pkg::snap_t rd_data,
  output logic           full,
  output logic           empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  psg_pkg::snap_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue pop while empty");
`endif

endmodule

// ===== hdl/psg_back.sv =====
// psg_back: turns channel snapshots into stereo levels in a three stage pipeline
// volume times preamp, divide by 100 via reciprocal, pan and sum; uses psg_pkg
module psg_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [7:0]                   preamp,
  input  logic [7:0]                   panning,
  input  logic                         q_valid,
  input  psg_pkg::snap_t               q_data,
  output logic                         pop,
  input  logic                         out_stall,
  output logic                         out_valid,
  output logic [psg_pkg::LEVEL_W-1:0]  out_left_level,
  output logic [psg_pkg::LEVEL_W-1:0]  out_right_level
);

  logic                                             en;
  logic                                             v1_r, v2_r, out_valid_r;
  logic [psg_pkg::NUM_CH-1:0]                       high1_r, high2_r;
  logic [psg_pkg::NUM_CH-1:0][psg_pkg::PROD_W-1:0]  prod1_r;
  logic [psg_pkg::NUM_CH-1:0][psg_pkg::QUOT_W-1:0]  quot2_r;
  logic [psg_pkg::NUM_CH-1:0][psg_pkg::PROD_W-1:0]  prod_c;
  logic [psg_pkg::NUM_CH-1:0][psg_pkg::RPROD_W-1:0] rprod_c;
  logic [psg_pkg::NUM_CH-1:0][psg_pkg::QUOT_W-1:0]  quot_c;
  logic [psg_pkg::LEVEL_W-1:0]                      left_c, right_c;
  logic [psg_pkg::LEVEL_W-1:0]                      left_r, right_r;

  // whole pipeline moves unless a finished result is held
  assign en  = !(out_valid_r && out_stall);
  assign pop = en && q_valid;

  always_comb begin
    for (int i = 0; i < psg_pkg::NUM_CH; i++) begin
      prod_c[i]  = psg_pkg::PROD_W'(psg_pkg::vol_lut(q_data.att[i])) *
                   psg_pkg::PROD_W'(preamp);
      rprod_c[i] = psg_pkg::RPROD_W'(prod1_r[i]) * psg_pkg::RPROD_W'(psg_pkg::RECIP);
      quot_c[i]  = rprod_c[i][psg_pkg::RECIP_SHIFT +: psg_pkg::QUOT_W];
    end
  end

  always_comb begin
    left_c  = '0;
    right_c = '0;
    for (int i = 0; i < psg_pkg::NUM_CH; i++) begin
      if (high2_r[i] && panning[psg_pkg::NUM_CH + i]) begin
        left_c = left_c + psg_pkg::LEVEL_W'(quot2_r[i]);
      end
      if (high2_r[i] && panning[i]) begin
        right_c = right_c + psg_pkg::LEVEL_W'(quot2_r[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= pop;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      high1_r <= q_data.high;
      prod1_r <= prod_c;
      high2_r <= high1_r;
      quot2_r <= quot_c;
      left_r  <= left_c;
      right_r <= right_c;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_left_level  = left_r;
  assign out_right_level = right_r;

`ifndef SYNTHESIS
  logic [psg_pkg::NUM_CH-1:0] div_ok;
  always_comb begin
    for (int i = 0; i < psg_pkg::NUM_CH; i++) begin
      div_ok[i] = ((psg_pkg::QUOT_W + 8)'(quot_c[i]) * psg_pkg::PCT_SCALE
                   <= (psg_pkg::QUOT_W + 8)'(prod1_r[i])) &&
                  ((psg_pkg::QUOT_W + 8)'(prod1_r[i]) -
                   (psg_pkg::QUOT_W + 8)'(quot_c[i]) * psg_pkg::PCT_SCALE
                   < psg_pkg::PCT_SCALE);
    end
  end
  a_div_exact: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> (div_ok == '1))
    else $error("divide by 100 out of range");
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(v2_r))
    else $error("result appeared without a pipeline item");
`endif

endmodule

// ===== bench/psg_level_checker.sv =====
// psg_level_checker: watches the request, result and register channels of the sound generator,
// keeps its own copy of the generator state and compares every stereo level result in order
// depends on psg_pkg for widths, operation codes and register indexes
`timescale 1ns / 1ps

module psg_level_checker
  import psg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 in_operation,
  input  logic [7:0]           in_data_byte,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [LEVEL_W-1:0]   out_left_level,
  input  logic [LEVEL_W-1:0]   out_right_level,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  output int                   mismatches,
  output int                   pending
);

  typedef struct packed {
    logic [LEVEL_W-1:0] left;
    logic [LEVEL_W-1:0] right;
  } levels_t;

  int vol_by_att [16] = '{2800, 2224, 1766, 1403, 1114, 885, 703, 558,
                          443, 352, 280, 222, 176, 140, 111, 0};

  // register settings
  bit       variant;
  bit [7:0] preamp_pct;
  bit [7:0] pan_mask;

  // generator state
  bit [2:0]  latch_idx;
  bit [9:0]  period [3];
  bit [3:0]  att [4];
  bit [2:0]  noise_ctl;
  bit [9:0]  cnt [4];
  bit [3:0]  pol;
  bit [15:0] lfsr;

  levels_t expected_levels [$];
  levels_t got, want;
  int      err_count;

  function automatic int tone_span(input int ch);
    int p;
    p = period[ch];
    if (p == 0) p = variant ? 1 : 1024;
    return p;
  endfunction

  function automatic int noise_span();
    if (noise_ctl[1:0] == 2'b11) return tone_span(2);
    return 16 << noise_ctl[1:0];
  endfunction

  function automatic bit [15:0] lfsr_seed();
    return 16'd1 << (14 + variant);
  endfunction

  task automatic clear_generator();
    latch_idx = REG_TONE1_ATT;
    for (int i = 0; i < 4; i++) begin
      if (i < 3) period[i] = '0;
      att[i] = 4'hf;
      cnt[i] = '0;
    end
    pol = '0;
    noise_ctl = '0;
    variant = 1'b1;
    preamp_pct = 8'd100;
    pan_mask = 8'hff;
    lfsr = lfsr_seed();
  endtask

  task automatic apply_bus_write(input bit [7:0] d);
    bit [2:0] idx;
    if (d[7]) latch_idx = d[6:4];
    idx = latch_idx;
    case (idx)
      REG_TONE0_PERIOD, REG_TONE1_PERIOD, REG_TONE2_PERIOD: begin
        if (d[7]) period[idx >> 1][3:0] = d[3:0];
        else period[idx >> 1][9:4] = d[5:0];
      end
      REG_NOISE_CTRL: begin
        noise_ctl = d[2:0];
        // sync mode starts the noise countdown in step with tone 2
        if (d[1:0] == 2'b11) cnt[3] = cnt[2];
        lfsr = lfsr_seed();
      end
      default: att[idx >> 1] = d[3:0];
    endcase
  endtask

  task automatic advance_tick();
    int span;
    bit fill;
    for (int i = 0; i < 4; i++) begin
      if (cnt[i] == 0) begin
        span = (i < 3) ? tone_span(i) : noise_span();
        pol[i] = ~pol[i];
        cnt[i] = 10'(span - 1);
        if (i == 3 && pol[3]) begin
          if (noise_ctl[2]) fill = ^(lfsr & (variant ? 16'h0009 : 16'h0006));
          else fill = lfsr[0];
          lfsr = (lfsr >> 1) | (16'(fill) << (14 + variant));
        end
      end else begin
        cnt[i] = cnt[i] - 10'd1;
      end
    end
  endtask

  function automatic levels_t mix_levels();
    int l, r, vol;
    bit high;
    l = 0;
    r = 0;
    for (int i = 0; i < 4; i++) begin
      high = (i < 3) ? pol[i] : lfsr[0];
      if (high) begin
        vol = vol_by_att[att[i]];
        l += (vol * (pan_mask[i + 4] ? int'(preamp_pct) : 0)) / 100;
        r += (vol * (pan_mask[i] ? int'(preamp_pct) : 0)) / 100;
      end
    end
    return '{left: LEVEL_W'(l), right: LEVEL_W'(r)};
  endfunction

  initial err_count = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_generator();
      expected_levels.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_VARIANT: variant = cfg_data[0];
          CFG_PREAMP:  preamp_pct = cfg_data;
          CFG_PANNING: pan_mask = cfg_data;
          default: ;
        endcase
      end
      // compare before predicting so a result never matches the prediction pushed for a request accepted alongside it
      if (out_valid && !out_stall) begin
        got = '{left: out_left_level, right: out_right_level};
        if (expected_levels.size() == 0) begin
          if (err_count < 10)
            $display("unexpected result: left %0d right %0d", got.left, got.right);
          err_count++;
        end else begin
          want = expected_levels.pop_front();
          if (got.left !== want.left || got.right !== want.right) begin
            if (err_count < 10)
              $display("level mismatch: expected left %0d right %0d, got left %0d right %0d",
                       want.left, want.right, got.left, got.right);
            err_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_operation == OP_TICK) advance_tick();
        else apply_bus_write(in_data_byte);
        expected_levels.push_back(mix_levels());
      end
    end
    mismatches <= err_count;
    pending <= expected_levels.size();
  end

endmodule

// ===== bench/tb_psg_tone_noise_generator.sv =====
// tb_psg_tone_noise_generator: stimulus, register phases, stalls and verdict for the sound generator
// depends on psg_pkg, the psg_tone_noise_generator rtl and psg_level_checker
`timescale 1ns / 1ps

module tb_psg_tone_noise_generator;
  import psg_pkg::*;

  localparam int HOLD_AT    = 350;
  localparam int CALM_LEN   = 150;
  localparam int HOLD_LEN   = 80;
  localparam int IDLE_LIMIT = 3000;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_operation;
  logic [7:0]           in_data_byte;
  logic                 out_valid;
  logic                 out_stall;
  logic [LEVEL_W-1:0]   out_left_level;
  logic [LEVEL_W-1:0]   out_right_level;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;

  int mismatches, pending;
  int sent = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  psg_tone_noise_generator dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_left_level (out_left_level),
    .out_right_level(out_right_level),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  psg_level_checker level_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_left_level (out_left_level),
    .out_right_level(out_right_level),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .pending        (pending)
  );

  always #10 clk = ~clk;

  function automatic logic [7:0] latch_byte(input logic [2:0] reg_idx, input logic [3:0] nib);
    return {1'b1, reg_idx, nib};
  endfunction

  task automatic send_item(input logic op, input logic [7:0] data);
    if (sent == HOLD_AT) begin
      calm = 1'b1;
      hold_req = 1'b1;
    end else if (sent == HOLD_AT + CALM_LEN) begin
      calm = 1'b0;
    end
    if (!calm && $urandom_range(99) < 4) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_data_byte <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // drop the request line and wait until every level result is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_settings(input bit variant, input logic [7:0] pre, input logic [7:0] pan);
    logic [CFG_IDX_W-1:0] idx [3];
    logic [7:0] val [3];
    idx = '{CFG_VARIANT, CFG_PREAMP, CFG_PANNING};
    val = '{{7'd0, variant}, pre, pan};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic play_random(input int n);
    int done, pick, run;
    logic [2:0] reg_idx;
    logic [5:0] upper;
    done = 0;
    while (done < n) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        run = $urandom_range(1, 16);
        repeat (run) send_item(OP_TICK, 8'($urandom));
        done += run;
      end else if (pick < 70) begin
        // tone period: latch low nibble, then data byte with the upper bits, mostly short
        case ($urandom_range(2))
          0: reg_idx = REG_TONE0_PERIOD;
          1: reg_idx = REG_TONE1_PERIOD;
          default: reg_idx = REG_TONE2_PERIOD;
        endcase
        upper = ($urandom_range(99) < 70) ? 6'd0 : 6'($urandom);
        send_item(OP_WRITE, latch_byte(reg_idx, 4'($urandom)));
        send_item(OP_WRITE, {1'b0, 1'($urandom), upper});
        done += 2;
      end else if (pick < 82) begin
        case ($urandom_range(3))
          0: reg_idx = REG_TONE0_ATT;
          1: reg_idx = REG_TONE1_ATT;
          2: reg_idx = REG_TONE2_ATT;
          default: reg_idx = REG_NOISE_ATT;
        endcase
        send_item(OP_WRITE, latch_byte(reg_idx, 4'($urandom)));
        done++;
        if ($urandom_range(3) == 0) begin
          send_item(OP_WRITE, {1'b0, 7'($urandom)});
          done++;
        end
      end else if (pick < 90) begin
        send_item(OP_WRITE, latch_byte(REG_NOISE_CTRL, 4'($urandom)));
        done++;
      end else begin
        send_item(OP_WRITE, 8'($urandom));
        done++;
      end
    end
  endtask

  // result side: random stalls plus one long hold-off to fill the queue
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_LEN;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 12);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("psg_tone_noise_generator regression: fail");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = OP_WRITE;
    in_data_byte = 8'h00;
    cfg_valid = 1'b0;
    cfg_index = CFG_VARIANT;
    cfg_data = 8'h00;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: silent start, loudest channels, zero and largest periods, noise modes
    send_item(OP_TICK, 8'h00);
    send_item(OP_WRITE, latch_byte(REG_TONE0_ATT, 4'h0));
    send_item(OP_WRITE, latch_byte(REG_TONE1_ATT, 4'h0));
    send_item(OP_WRITE, latch_byte(REG_TONE2_ATT, 4'h0));
    send_item(OP_WRITE, latch_byte(REG_NOISE_ATT, 4'h0));
    send_item(OP_TICK, 8'hff);
    send_item(OP_TICK, 8'h00);
    send_item(OP_WRITE, latch_byte(REG_TONE0_PERIOD, 4'hf));
    send_item(OP_WRITE, 8'h3f);
    send_item(OP_WRITE, latch_byte(REG_TONE1_PERIOD, 4'h2));
    send_item(OP_WRITE, 8'h40);
    send_item(OP_WRITE, latch_byte(REG_TONE2_PERIOD, 4'h3));
    send_item(OP_WRITE, 8'h00);
    // white noise clocked from tone 2
    send_item(OP_WRITE, latch_byte(REG_NOISE_CTRL, 4'h7));
    repeat (4) send_item(OP_TICK, 8'h55);
    // periodic noise from tone 2, unused bit 3 set
    send_item(OP_WRITE, latch_byte(REG_NOISE_CTRL, 4'hb));
    repeat (3) send_item(OP_TICK, 8'haa);
    send_item(OP_WRITE, 8'h7a);
    send_item(OP_WRITE, latch_byte(REG_TONE0_ATT, 4'hf));
    send_item(OP_WRITE, 8'h45);
    send_item(OP_TICK, 8'h80);

    play_random(200);
    for (int phase = 1; phase < 6; phase++) begin
      drain();
      case (phase)
        1: program_settings(1'b0, 8'd200, 8'hff);
        2: program_settings(1'b1, 8'd0, 8'h00);
        3: program_settings(1'b0, 8'd255, 8'hf0);
        4: program_settings(1'b1, 8'd1, 8'h0f);
        default: program_settings(1'($urandom), 8'($urandom), 8'($urandom));
      endcase
      case (phase)
        1: play_random(300);
        2: play_random(100);
        3: play_random(250);
        4: play_random(150);
        default: play_random(200);
      endcase
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("psg_tone_noise_generator regression: pass");
    end else begin
      $display("psg_tone_noise_generator regression: fail");
    end
    $finish;
  end

endmodule
